[sv/ktaf_pkg.sv]
// ----------------------------------------------------------------------------
// ktaf_pkg
// Shared types and constants of the tilt-angle Kalman filter.
// ----------------------------------------------------------------------------
package ktaf_pkg;

    localparam int unsigned REG_W  = 31;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned ACC_W  = 66;

    localparam logic [1:0] REG_ANGLE_NOISE = 2'd0;
    localparam logic [1:0] REG_BIAS_NOISE  = 2'd1;
    localparam logic [1:0] REG_MEAS_NOISE  = 2'd2;
    localparam logic [1:0] REG_PERIOD      = 2'd3;

    localparam logic [REG_W-1:0] RESET_ANGLE_NOISE = 31'd16777;
    localparam logic [REG_W-1:0] RESET_BIAS_NOISE  = 31'd50332;
    localparam logic [REG_W-1:0] RESET_MEAS_NOISE  = 31'd503316;
    localparam logic [REG_W-1:0] RESET_PERIOD      = 31'd167772;

    localparam logic signed [DATA_W-1:0] ONE_Q24 = 32'sd16777216;

    // Operations of the shared multiply unit
    typedef struct packed {
        logic                     start;
        logic signed [DATA_W:0]   op_a;
        logic signed [DATA_W:0]   op_b;
    } t_mul_req;

    // Operations of the shared divider
    typedef struct packed {
        logic                     start;
        logic signed [55:0]       num;
        logic signed [DATA_W:0]   den;
    } t_div_req;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(32'sh7FFFFFFF);
        lo = -ACC_W'(64'sd2147483648);
        if (x > hi) begin
            return 32'sh7FFFFFFF;
        end else if (x < lo) begin
            return 32'sh80000000;
        end
        return x[DATA_W-1:0];
    endfunction

    function automatic logic signed [ACC_W-1:0] sx(input logic signed [DATA_W-1:0] v);
        return ACC_W'(v);
    endfunction

endpackage

[sv/kalman_tilt_angle_filter.sv]
// ----------------------------------------------------------------------------
// kalman_tilt_angle_filter
// Angle/bias Kalman filter sequenced over one multiplier and a serial divider.
// Seeding outputs the measured angle; filtering computes both gains with two
// serial divisions, skipped when the innovation variance is not positive.
// One item in flight: ready is low until its output transaction is accepted.
// Reset: synchronous active low; registers to defaults, filter unseeded.
// ----------------------------------------------------------------------------
module kalman_tilt_angle_filter (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,   // measured_angle, angular_rate
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [95:0]  m_axis_tdata,   // estimated_angle, estimated_bias, unbiased_rate
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_index,
    input  logic [30:0]  i_cfg_data
);
    import ktaf_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_MUL  = 8'b00000010,
        S_WAIT = 8'b00000100,
        S_DIV  = 8'b00001000,
        S_DWT  = 8'b00010000,
        S_STEP = 8'b00100000,
        S_OUT  = 8'b01000000,
        S_SEED = 8'b10000000
    } t_state;

    t_state r_state;
    logic [4:0] r_step;
    logic [REG_W-1:0] r_q_a, r_q_b, r_r, r_dt;
    logic signed [31:0] r_ang, r_bias, r_p00, r_p01, r_p10, r_p11;
    logic signed [31:0] r_z, r_rate, r_pred, r_inner, r_y, r_k0, r_k1;
    logic signed [ACC_W-1:0] r_drift;
    logic r_seeded;
    logic signed [ACC_W-1:0] r_s;
    t_mul_req w_mreq;
    t_div_req w_dreq;
    logic signed [ACC_W-1:0] w_prod, w_quot;
    logic w_ddone;
    logic signed [32:0] w_a, w_b;

    ktaf_mul u_mul (.i_clk(i_clk), .i_req(w_mreq), .o_prod(w_prod));
    ktaf_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_dreq),
                    .o_done(w_ddone), .o_quot(w_quot));

    // operand selection per multiply step
    always_comb begin
        w_a = '0;
        w_b = '0;
        case (r_step)
            5'd0:  begin w_a = $signed({2'b0, r_dt}); w_b = 33'(r_rate); end
            5'd1:  begin w_a = $signed({2'b0, r_dt}); w_b = 33'(r_p11); end
            5'd2:  begin w_a = $signed({2'b0, r_dt}); w_b = 33'(r_inner); end
            5'd3:  begin w_a = $signed({2'b0, r_q_b}); w_b = $signed({2'b0, r_dt}); end
            5'd6:  begin w_a = 33'(r_k0); w_b = 33'(r_y); end
            5'd7:  begin w_a = 33'(r_k1); w_b = 33'(r_y); end
            5'd8:  begin w_a = 33'(r_k1); w_b = 33'(r_p00); end
            5'd9:  begin w_a = 33'(r_k1); w_b = 33'(r_p01); end
            5'd10: begin w_a = 33'(r_k0); w_b = 33'(r_p00); end
            5'd11: begin w_a = 33'(r_k0); w_b = 33'(r_p01); end
            default: ;
        endcase
    end

    assign w_mreq.start = (r_state == S_MUL);
    assign w_mreq.op_a  = w_a;
    assign w_mreq.op_b  = w_b;
    assign w_dreq.start = (r_state == S_DIV);
    assign w_dreq.num   = (r_step == 5'd4) ? 56'(r_p00) <<< 24 : 56'(r_p10) <<< 24;
    assign w_dreq.den   = 33'(32'(r_s));

    assign s_axis_tready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_q_a <= RESET_ANGLE_NOISE;
            r_q_b <= RESET_BIAS_NOISE;
            r_r <= RESET_MEAS_NOISE;
            r_dt <= RESET_PERIOD;
            r_ang <= '0;
            r_bias <= '0;
            r_p00 <= ONE_Q24;
            r_p01 <= '0;
            r_p10 <= '0;
            r_p11 <= ONE_Q24;
            r_seeded <= 1'b0;
            m_axis_tvalid <= 1'b0;
            r_step <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_ANGLE_NOISE: r_q_a <= i_cfg_data;
                    REG_BIAS_NOISE:  r_q_b <= i_cfg_data;
                    REG_MEAS_NOISE:  r_r <= i_cfg_data;
                    REG_PERIOD:      r_dt <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_z <= s_axis_tdata[31:0];
                        r_rate <= sat32(sx(s_axis_tdata[63:32]) - sx(r_bias));
                        r_step <= '0;
                        r_state <= r_seeded ? S_MUL : S_SEED;
                    end
                end
                S_SEED: begin
                    r_ang <= r_z;
                    r_bias <= '0;
                    r_p00 <= ONE_Q24;
                    r_p01 <= '0;
                    r_p10 <= '0;
                    r_p11 <= ONE_Q24;
                    r_seeded <= 1'b1;
                    m_axis_tvalid <= 1'b1;
                    r_state <= S_OUT;
                end
                S_MUL: r_state <= S_WAIT;
                S_WAIT: begin
                    r_state <= S_MUL;
                    r_step <= r_step + 5'd1;
                    case (r_step)
                        5'd0: r_pred <= sat32(sx(r_ang) + w_prod);
                        5'd1: begin
                            r_drift <= w_prod;
                            r_inner <= sat32(w_prod - sx(r_p01) - sx(r_p10)
                                             + ACC_W'(r_q_a));
                        end
                        5'd2: r_p00 <= sat32(sx(r_p00) + w_prod);
                        5'd3: begin
                            r_p01 <= sat32(sx(r_p01) - r_drift);
                            r_p10 <= sat32(sx(r_p10) - r_drift);
                            r_p11 <= sat32(sx(r_p11) + w_prod);
                            r_y <= sat32(sx(r_z) - sx(r_pred));
                            r_s <= sx(r_p00) + ACC_W'(r_r);
                            r_state <= S_STEP;
                        end
                        5'd6: r_ang <= sat32(sx(r_pred) + w_prod);
                        5'd7: r_bias <= sat32(sx(r_bias) + w_prod);
                        5'd8: r_p10 <= sat32(sx(r_p10) - w_prod);
                        5'd9: r_p11 <= sat32(sx(r_p11) - w_prod);
                        5'd10: r_p00 <= sat32(sx(r_p00) - w_prod);
                        default: begin
                            r_p01 <= sat32(sx(r_p01) - w_prod);
                            m_axis_tvalid <= 1'b1;
                            r_state <= S_OUT;
                        end
                    endcase
                end
                S_STEP: begin
                    if (r_s > 0) begin
                        r_state <= S_DIV;
                    end else begin
                        r_k0 <= '0;
                        r_k1 <= '0;
                        r_step <= 5'd6;
                        r_state <= S_MUL;
                    end
                end
                S_DIV: r_state <= S_DWT;
                S_DWT: begin
                    if (w_ddone) begin
                        if (r_step == 5'd4) begin
                            r_k0 <= sat32(w_quot);
                            r_step <= 5'd5;
                            r_state <= S_DIV;
                        end else begin
                            r_k1 <= sat32(w_quot);
                            r_step <= 5'd6;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        m_axis_tvalid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tdata = {r_rate, r_bias, r_ang};

endmodule

[sv/ktaf_mul.sv]
// ----------------------------------------------------------------------------
// ktaf_mul
// Shared 33x33 signed multiplier with floor shift by 24, registered result.
// ----------------------------------------------------------------------------
module ktaf_mul (
    input  logic                      i_clk,
    input  ktaf_pkg::t_mul_req        i_req,
    output logic signed [ktaf_pkg::ACC_W-1:0] o_prod
);
    import ktaf_pkg::*;

    logic signed [65:0] r_full;

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_full <= i_req.op_a * i_req.op_b;
        end
    end

    assign o_prod = r_full >>> 24;
endmodule

[sv/ktaf_div.sv]
// ----------------------------------------------------------------------------
// ktaf_div
// Restoring signed divider, one quotient bit per cycle, truncates to zero.
// ----------------------------------------------------------------------------
module ktaf_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  ktaf_pkg::t_div_req        i_req,
    output logic                      o_done,
    output logic signed [ktaf_pkg::ACC_W-1:0] o_quot
);
    import ktaf_pkg::*;

    logic [55:0] r_q;
    logic [55:0] r_rem;
    logic [31:0] r_d;
    logic        r_neg;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [56:0] w_trial;
    logic [55:0] n_rem;

    assign w_trial = {r_rem, r_q[55]} - {25'd0, r_d};
    assign n_rem   = w_trial[56] ? {r_rem[54:0], r_q[55]} : w_trial[55:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_req.start) begin
                r_q    <= i_req.num[55] ? 56'(-i_req.num) : 56'(i_req.num);
                r_d    <= 32'(i_req.den);
                r_neg  <= i_req.num[55];
                r_rem  <= '0;
                r_cnt  <= 6'd55;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_q   <= {r_q[54:0], ~w_trial[56]};
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
                r_cnt <= r_cnt - 6'd1;
            end
        end
    end

    assign o_quot = r_neg ? -ACC_W'($signed({1'b0, r_q})) : ACC_W'($signed({1'b0, r_q}));
endmodule

[tb/sv/tb_kalman_tilt_angle_filter.sv]
// ----------------------------------------------------------------------------
// tb_kalman_tilt_angle_filter
// Streams angle/rate samples into the tilt Kalman filter under random source
// gaps and sink stalls, predicts every estimate with a fixed-point model of
// the filter and compares each output transaction field by field.
// ----------------------------------------------------------------------------
module tb_kalman_tilt_angle_filter;
    timeunit 1ns;
    timeprecision 1ps;

    import ktaf_pkg::*;

    typedef struct packed {
        logic signed [31:0] rate;
        logic signed [31:0] angle;
    } t_imu_item;

    typedef struct packed {
        logic signed [31:0] unbiased_rate;
        logic signed [31:0] bias;
        logic signed [31:0] angle;
    } t_estimate;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = REG_ANGLE_NOISE;
    logic [30:0] i_cfg_data = '0;

    kalman_tilt_angle_filter u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #2ns i_clk = ~i_clk;

    // filter model state
    logic [30:0] q_angle, q_bias, r_meas, dt_reg;
    longint      est_angle, est_bias, p_aa, p_ab, p_ba, p_bb;
    bit          is_seeded;

    t_imu_item sample_q[$];
    t_estimate estimate_q[$];
    int        errors = 0;
    int        n_checked = 0;
    int        n_pushed = 0;
    int        n_sent = 0;
    int        n_cfg = 0;
    longint    cycles = 0;
    bit        hold_src = 1'b0;
    bit        in_taken = 1'b0;
    int        src_wait = 0;
    int        sink_wait = 0;

    function automatic longint clamp32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return (a * b) >>> 24;
    endfunction

    function automatic t_estimate filter_step(t_imu_item s);
        t_estimate e;
        longint z, w, dt, rate, pred, inner, drift, y, sv, k0, k1;
        z = s.angle;
        w = s.rate;
        dt = longint'(dt_reg);
        rate = clamp32(w - est_bias);
        if (!is_seeded) begin
            est_angle = z;
            est_bias = 0;
            p_aa = 64'sd16777216; p_ab = 0; p_ba = 0; p_bb = 64'sd16777216;
            is_seeded = 1'b1;
        end else begin
            pred = clamp32(est_angle + qmul(dt, rate));
            inner = clamp32(qmul(dt, p_bb) - p_ab - p_ba + longint'(q_angle));
            drift = qmul(dt, p_bb);
            p_aa = clamp32(p_aa + qmul(dt, inner));
            p_ab = clamp32(p_ab - drift);
            p_ba = clamp32(p_ba - drift);
            p_bb = clamp32(p_bb + qmul(longint'(q_bias), dt));
            y = clamp32(z - pred);
            sv = p_aa + longint'(r_meas);
            k0 = 0;
            k1 = 0;
            if (sv > 0) begin
                k0 = clamp32((p_aa * 64'sd16777216) / sv);
                k1 = clamp32((p_ba * 64'sd16777216) / sv);
            end
            est_angle = clamp32(pred + qmul(k0, y));
            est_bias = clamp32(est_bias + qmul(k1, y));
            // covariance update uses the predicted terms
            begin
                longint a0, a1, b0, b1;
                a0 = p_aa; a1 = p_ab; b0 = p_ba; b1 = p_bb;
                p_aa = clamp32(a0 - qmul(k0, a0));
                p_ab = clamp32(a1 - qmul(k0, a1));
                p_ba = clamp32(b0 - qmul(k1, a0));
                p_bb = clamp32(b1 - qmul(k1, a1));
            end
        end
        e.angle = est_angle[31:0];
        e.bias = est_bias[31:0];
        e.unbiased_rate = rate[31:0];
        return e;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch on result %0d, %s: got %h expected %h", n_checked, field, got,
            want);
    endtask

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!s_axis_tvalid || in_taken) begin
                if (in_taken) begin
                    n_sent++;
                    in_taken = 1'b0;
                end
                if (src_wait > 0) begin
                    src_wait--;
                    s_axis_tvalid <= 1'b0;
                end else if (sample_q.size() > 0 && !hold_src) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= sample_q.pop_front();
                    src_wait = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 13));
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            if (sink_wait > 0) begin
                sink_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // monitor: prediction at input acceptance, checking at output acceptance
    always @(posedge i_clk) begin
        t_estimate got, want;
        cycles++;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            estimate_q.push_back(filter_step(t_imu_item'(s_axis_tdata)));
            in_taken = 1'b1;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_estimate'(m_axis_tdata);
            if (estimate_q.size() == 0) begin
                errors++;
                $display("unexpected output transaction %h", m_axis_tdata);
            end else begin
                want = estimate_q.pop_front();
                if (got.angle !== want.angle)
                    report_mismatch("estimated_angle", got.angle, want.angle);
                if (got.bias !== want.bias)
                    report_mismatch("estimated_bias", got.bias, want.bias);
                if (got.unbiased_rate !== want.unbiased_rate)
                    report_mismatch("unbiased_rate", got.unbiased_rate, want.unbiased_rate);
            end
            n_checked++;
            sink_wait <= ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 13));
        end
    end

    always @(posedge i_clk) begin
        if (cycles > 64'd1500000) begin
            $display("tb_kalman_tilt_angle_filter failed");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [30:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_ANGLE_NOISE: q_angle = val;
            REG_BIAS_NOISE:  q_bias = val;
            REG_MEAS_NOISE:  r_meas = val;
            default:         dt_reg = val;
        endcase
        n_cfg++;
    endtask

    task automatic drain();
        wait (n_checked == n_pushed);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_angle();
        case ($urandom_range(0, 5))
            0:       return $urandom();
            1:       return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
            default: return 32'($signed($urandom_range(0, 180 << 17)) - (90 << 16));
        endcase
    endfunction

    function automatic logic [31:0] rand_rate();
        case ($urandom_range(0, 5))
            0:       return $urandom();
            1:       return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
            default: return 32'($signed($urandom_range(0, 500 << 17)) - (250 << 16));
        endcase
    endfunction

    task automatic push_sample(logic [31:0] a, logic [31:0] r);
        t_imu_item s;
        s.angle = a;
        s.rate = r;
        sample_q.push_back(s);
        n_pushed++;
    endtask

    initial begin
        q_angle = RESET_ANGLE_NOISE;
        q_bias = RESET_BIAS_NOISE;
        r_meas = RESET_MEAS_NOISE;
        dt_reg = RESET_PERIOD;
        is_seeded = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // seeding item, then extremes at default tuning
        push_sample(32'h0012_0000, 32'h0003_0000);
        push_sample(32'h7FFFFFFF, 32'h7FFFFFFF);
        push_sample(32'h80000000, 32'h80000000);
        push_sample(32'h80000000, 32'h7FFFFFFF);
        push_sample(32'h7FFFFFFF, 32'h80000000);
        push_sample(32'h0, 32'h0);
        push_sample(32'hFFFFFFFF, 32'h00000001);
        push_sample(32'h5555AAAA, 32'hAAAA5555);
        push_sample(32'h0, 32'hFFFFFFFF);
        drain();

        // extreme tuning: zero noise, huge period, non-positive innovation variance
        write_reg(REG_ANGLE_NOISE, 31'h0);
        write_reg(REG_BIAS_NOISE, 31'h0);
        write_reg(REG_MEAS_NOISE, 31'h0);
        write_reg(REG_PERIOD, 31'h7FFFFFFF);
        repeat (6) push_sample(rand_angle(), rand_rate());
        drain();
        write_reg(REG_ANGLE_NOISE, 31'h7FFFFFFF);
        write_reg(REG_BIAS_NOISE, 31'h7FFFFFFF);
        write_reg(REG_MEAS_NOISE, 31'h7FFFFFFF);
        write_reg(REG_PERIOD, 31'h0);
        repeat (6) push_sample(rand_angle(), rand_rate());
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            if (ph % 3 == 0) begin
                write_reg(REG_ANGLE_NOISE, RESET_ANGLE_NOISE);
                write_reg(REG_BIAS_NOISE, RESET_BIAS_NOISE);
                write_reg(REG_MEAS_NOISE, RESET_MEAS_NOISE);
                write_reg(REG_PERIOD, RESET_PERIOD);
            end else begin
                write_reg(REG_ANGLE_NOISE,
                    31'($urandom_range(0, 1) ? $urandom() : $urandom_range(0, 1 << 20)));
                write_reg(REG_BIAS_NOISE,
                    31'($urandom_range(0, 1) ? $urandom() : $urandom_range(0, 1 << 20)));
                write_reg(REG_MEAS_NOISE,
                    31'($urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(1, 1 << 24)));
                write_reg(REG_PERIOD,
                    31'($urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(1, 1 << 22)));
            end
            for (int i = 0; i < 53; i++) begin
                push_sample(rand_angle(), rand_rate());
                if (i == 25 && ph == 4) begin
                    wait (sample_q.size() == 0);
                    hold_src = 1'b1;
                    wait (n_checked == n_pushed);
                    hold_src = 1'b0;
                end
            end
            drain();
        end

        $display("covered %0d samples and %0d checked estimates over %0d register writes",
            n_sent, n_checked, n_cfg);
        if (errors == 0) begin
            $display("tb_kalman_tilt_angle_filter passed");
        end else begin
            $display("tb_kalman_tilt_angle_filter failed");
        end
        $finish;
    end
endmodule

[sim.f]
sv/ktaf_pkg.sv
sv/ktaf_mul.sv
sv/ktaf_div.sv
sv/kalman_tilt_angle_filter.sv
tb/sv/tb_kalman_tilt_angle_filter.sv
